/* rtl/bfsp_pkg.sv */
// bfsp_pkg: shared types and codes for the shortest path core
// no dependencies
`timescale 1ns / 1ps
package bfsp_pkg;

  localparam int KEY_W  = 16;
  localparam int WIN_W  = 32;
  localparam int DIST_W = 40;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_EDGE   = 2'd2;
  localparam logic [1:0] OP_QUERY  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNREACH = 2'd1;
  localparam logic [1:0] ST_NEGCYC  = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [1:0]              op;
    logic [KEY_W-1:0]        key_a;
    logic [KEY_W-1:0]        key_b;
    logic signed [WIN_W-1:0] weight;
  } in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DIST_W-1:0] distance;
  } out_t;

endpackage

/* rtl/bellman_ford_shortest_path_core.sv */
// bellman_ford_shortest_path_core: graph build and shortest path query engine
// uses bfsp_pkg and bfsp_ram (key table, edge matrix, distance table)
// a query first searches the key table, then runs n rounds plus the cycle check, each
// visiting every row and every edge slot of each reached row, then reads the result
// append writes the key table directly, add edge searches the key table first; one item at a time
// reset and clear sweep every entry of the edge matrix, one entry a cycle,
// while no input is accepted
`timescale 1ns / 1ps
module bellman_ford_shortest_path_core #(
  parameter int MAX_NODES   = 64,
  parameter int WEIGHT_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  bfsp_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output bfsp_pkg::out_t   out_data
);
  import bfsp_pkg::*;

  localparam int IW  = $clog2(MAX_NODES);
  localparam int CW  = $clog2(MAX_NODES + 1);
  localparam int EW  = 2 * IW;
  localparam int WB  = WEIGHT_BITS;
  localparam int WX  = (WB > WIN_W) ? WB : WIN_W;
  localparam int SW  = ((WB > DIST_W) ? WB : DIST_W) + 1;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_SRD  = 4'd2;
  localparam logic [3:0] S_SCMP = 4'd3;
  localparam logic [3:0] S_SEND = 4'd4;
  localparam logic [3:0] S_QINI = 4'd5;
  localparam logic [3:0] S_ROW  = 4'd6;
  localparam logic [3:0] S_ROWD = 4'd7;
  localparam logic [3:0] S_ERD  = 4'd8;
  localparam logic [3:0] S_EADD = 4'd9;
  localparam logic [3:0] S_EUPD = 4'd10;
  localparam logic [3:0] S_DRD  = 4'd11;
  localparam logic [3:0] S_FIN  = 4'd12;

  logic [3:0]               state_r, state_nxt;
  logic [EW-1:0]            clr_r, clr_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic                     outv_r, outv_nxt;
  out_t                     out_r, out_nxt;
  logic [1:0]               op_r, op_nxt;
  logic [KEY_W-1:0]         ka_r, ka_nxt, kb_r, kb_nxt;
  logic signed [WB-1:0]     w_r, w_nxt;
  logic [CW-1:0]            k_r, k_nxt;
  logic [IW-1:0]            s_r, s_nxt, d_r, d_nxt;
  logic                     sf_r, sf_nxt, df_r, df_nxt;
  logic [CW-1:0]            rnd_r, rnd_nxt;
  logic [IW-1:0]            i_r, i_nxt, j_r, j_nxt;
  logic                     chk_r, chk_nxt, neg_r, neg_nxt;
  logic signed [DIST_W-1:0] di_r, di_nxt, dj_r, dj_nxt;
  logic [MAX_NODES-1:0]     reach_r, reach_nxt;
  logic signed [SW-1:0]     sum_r, sum_nxt;
  logic                     ev_r, ev_nxt, rj_r, rj_nxt;

  logic                     key_we;
  logic [IW-1:0]            key_waddr, key_raddr;
  logic [KEY_W-1:0]         key_wdata, key_rdata;
  logic                     edge_we;
  logic [EW-1:0]            edge_waddr, edge_raddr;
  logic [WB:0]              edge_wdata, edge_rdata;
  logic                     dist_we;
  logic [IW-1:0]            dist_waddr, dist_raddr;
  logic [DIST_W-1:0]        dist_wdata, dist_rdata;

  logic signed [WX-1:0]     w_ext, w_hi, w_lo, w_sat;
  logic signed [SW-1:0]     d_hi, d_lo;
  logic signed [DIST_W-1:0] c_sat;
  logic                     j_last, i_last, r_last;

  bfsp_ram #(.WIDTH(KEY_W), .DEPTH(1 << IW)) u_key (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
    .raddr(key_raddr), .rdata(key_rdata)
  );

  bfsp_ram #(.WIDTH(WB + 1), .DEPTH(1 << EW)) u_edge (
    .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
    .raddr(edge_raddr), .rdata(edge_rdata)
  );

  bfsp_ram #(.WIDTH(DIST_W), .DEPTH(1 << IW)) u_dist (
    .clk(clk), .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
    .raddr(dist_raddr), .rdata(dist_rdata)
  );

  assign in_stall  = (state_r != S_IDLE) || outv_r;
  assign out_valid = outv_r;
  assign out_data  = out_r;

  assign w_ext = WX'(in_data.weight);
  assign w_hi  = {{(WX - WB + 1){1'b0}}, {(WB - 1){1'b1}}};
  assign w_lo  = ~w_hi;
  assign w_sat = (w_ext > w_hi) ? w_hi : ((w_ext < w_lo) ? w_lo : w_ext);

  assign d_hi  = {{(SW - DIST_W + 1){1'b0}}, {(DIST_W - 1){1'b1}}};
  assign d_lo  = ~d_hi;
  assign c_sat = (sum_r > d_hi) ? DIST_W'(d_hi) :
                 ((sum_r < d_lo) ? DIST_W'(d_lo) : DIST_W'(sum_r));

  assign j_last = (CW'(j_r) == cnt_r - 1'b1);
  assign i_last = (CW'(i_r) == cnt_r - 1'b1);
  assign r_last = (rnd_r == cnt_r - 1'b1);

  always_comb begin
    state_nxt = state_r;  clr_nxt = clr_r;   cnt_nxt = cnt_r;
    outv_nxt  = outv_r;   out_nxt = out_r;   op_nxt  = op_r;
    ka_nxt    = ka_r;     kb_nxt  = kb_r;    w_nxt   = w_r;
    k_nxt     = k_r;      s_nxt   = s_r;     d_nxt   = d_r;
    sf_nxt    = sf_r;     df_nxt  = df_r;    rnd_nxt = rnd_r;
    i_nxt     = i_r;      j_nxt   = j_r;     chk_nxt = chk_r;
    neg_nxt   = neg_r;    di_nxt  = di_r;    dj_nxt  = dj_r;
    reach_nxt = reach_r;  sum_nxt = sum_r;   ev_nxt  = ev_r;
    rj_nxt    = rj_r;

    key_we     = 1'b0;
    key_waddr  = cnt_r[IW-1:0];
    key_wdata  = in_data.key_a;
    key_raddr  = k_r[IW-1:0];
    edge_we    = 1'b0;
    edge_waddr = clr_r;
    edge_wdata = '0;
    edge_raddr = {i_r, j_r};
    dist_we    = 1'b0;
    dist_waddr = j_r;
    dist_wdata = c_sat;
    dist_raddr = j_r;

    if (outv_r && !out_stall) begin
      outv_nxt = 1'b0;
    end

    case (state_r)
      S_CLR: begin
        edge_we = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (&clr_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          op_nxt = in_data.op;
          ka_nxt = in_data.key_a;
          kb_nxt = in_data.key_b;
          w_nxt  = WB'(w_sat);
          k_nxt  = '0;
          sf_nxt = 1'b0;
          df_nxt = 1'b0;
          case (in_data.op)
            OP_CLEAR: begin
              cnt_nxt   = '0;
              clr_nxt   = '0;
              state_nxt = S_CLR;
            end
            OP_APPEND: begin
              if (cnt_r < CW'(MAX_NODES)) begin
                key_we  = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            default: begin
              state_nxt = S_SRD;
            end
          endcase
        end
      end
      S_SRD: begin
        state_nxt = (k_r == cnt_r) ? S_SEND : S_SCMP;
      end
      S_SCMP: begin
        if (!sf_r && key_rdata == ka_r) begin
          sf_nxt = 1'b1;
          s_nxt  = k_r[IW-1:0];
        end
        if (!df_r && key_rdata == kb_r) begin
          df_nxt = 1'b1;
          d_nxt  = k_r[IW-1:0];
        end
        k_nxt     = k_r + 1'b1;
        state_nxt = S_SRD;
      end
      S_SEND: begin
        state_nxt = S_IDLE;
        if (op_r == OP_EDGE) begin
          if (sf_r && df_r) begin
            edge_we    = 1'b1;
            edge_waddr = {s_r, d_r};
            edge_wdata = {1'b1, w_r};
          end
        end else if (!(sf_r && df_r)) begin
          outv_nxt = 1'b1;
          out_nxt  = '{status: ST_UNKNOWN, distance: '0};
        end else begin
          state_nxt = S_QINI;
        end
      end
      S_QINI: begin
        reach_nxt       = '0;
        reach_nxt[s_r]  = 1'b1;
        dist_we         = 1'b1;
        dist_waddr      = s_r;
        dist_wdata      = '0;
        i_nxt           = '0;
        rnd_nxt         = '0;
        chk_nxt         = 1'b0;
        neg_nxt         = 1'b0;
        state_nxt       = S_ROW;
      end
      S_ROW: begin
        dist_raddr = i_r;
        if (reach_r[i_r]) begin
          state_nxt = S_ROWD;
        end else if (!i_last) begin
          i_nxt = i_r + 1'b1;
        end else if (!chk_r && !r_last) begin
          rnd_nxt = rnd_r + 1'b1;
          i_nxt   = '0;
        end else if (!chk_r) begin
          chk_nxt = 1'b1;
          i_nxt   = '0;
        end else begin
          state_nxt = S_DRD;
        end
      end
      S_ROWD: begin
        di_nxt    = dist_rdata;
        j_nxt     = '0;
        state_nxt = S_ERD;
      end
      S_ERD: begin
        state_nxt = S_EADD;
      end
      S_EADD: begin
        ev_nxt    = edge_rdata[WB];
        sum_nxt   = SW'(di_r) + SW'($signed(edge_rdata[WB-1:0]));
        dj_nxt    = dist_rdata;
        rj_nxt    = reach_r[j_r];
        state_nxt = S_EUPD;
      end
      S_EUPD: begin
        if (ev_r) begin
          if (!chk_r) begin
            if (!rj_r || c_sat < dj_r) begin
              dist_we        = 1'b1;
              reach_nxt[j_r] = 1'b1;
              if (j_r == i_r) begin
                di_nxt = c_sat;
              end
            end
          end else if (!rj_r || sum_r < SW'(dj_r)) begin
            neg_nxt = 1'b1;
          end
        end
        if (!j_last) begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_ERD;
        end else if (!i_last) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_ROW;
        end else if (!chk_r && !r_last) begin
          rnd_nxt   = rnd_r + 1'b1;
          i_nxt     = '0;
          state_nxt = S_ROW;
        end else if (!chk_r) begin
          chk_nxt   = 1'b1;
          i_nxt     = '0;
          state_nxt = S_ROW;
        end else begin
          state_nxt = S_DRD;
        end
      end
      S_DRD: begin
        dist_raddr = d_r;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        outv_nxt = 1'b1;
        if (neg_r) begin
          out_nxt = '{status: ST_NEGCYC, distance: '0};
        end else if (!reach_r[d_r]) begin
          out_nxt = '{status: ST_UNREACH, distance: '0};
        end else begin
          out_nxt = '{status: ST_OK, distance: dist_rdata};
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      cnt_r   <= '0;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
      outv_r  <= outv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r   <= out_nxt;   op_r  <= op_nxt;   ka_r  <= ka_nxt;
    kb_r    <= kb_nxt;    w_r   <= w_nxt;    k_r   <= k_nxt;
    s_r     <= s_nxt;     d_r   <= d_nxt;    sf_r  <= sf_nxt;
    df_r    <= df_nxt;    rnd_r <= rnd_nxt;  i_r   <= i_nxt;
    j_r     <= j_nxt;     chk_r <= chk_nxt;  neg_r <= neg_nxt;
    di_r    <= di_nxt;    dj_r  <= dj_nxt;   reach_r <= reach_nxt;
    sum_r   <= sum_nxt;   ev_r  <= ev_nxt;   rj_r  <= rj_nxt;
  end

endmodule

/* rtl/bfsp_ram.sv */
// bfsp_ram: generic single write, single read ram with registered read
// no dependencies
`timescale 1ns / 1ps
module bfsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* bench/bellman_ford_shortest_path_core_tb.sv */
// bellman_ford_shortest_path_core_tb: builds small graphs, runs path queries and checks answers
// depends on bfsp_pkg and bellman_ford_shortest_path_core; holds its own shortest path predictor
`timescale 1ns / 1ps
module bellman_ford_shortest_path_core_tb;
  import bfsp_pkg::*;

  localparam int NODES = 64;
  localparam int IDLE_LIMIT = 2000000;
  localparam longint D_MAX = 64'sd549755813887;
  localparam longint D_MIN = -D_MAX - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int mismatches = 0;
  int idle_cycles = 0;

  logic [15:0] key_tab[NODES];
  int node_cnt = 0;
  bit edge_ok[NODES*NODES];
  longint edge_w[NODES*NODES];
  out_t answer_q[$];

  bellman_ford_shortest_path_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #1 clk = ~clk;

  function automatic void graph_clear();
    node_cnt = 0;
    foreach (key_tab[i]) key_tab[i] = '0;
    foreach (edge_ok[i]) begin
      edge_ok[i] = 1'b0;
      edge_w[i] = 0;
    end
  endfunction

  function automatic int slot_of(logic [15:0] k);
    for (int i = 0; i < node_cnt; i++) begin
      if (key_tab[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic longint sat40(longint v);
    if (v > D_MAX) return D_MAX;
    if (v < D_MIN) return D_MIN;
    return v;
  endfunction

  function automatic out_t path_answer(logic [15:0] ka, logic [15:0] kb);
    out_t r;
    int s;
    int d;
    bit reached[NODES];
    longint dist_v[NODES];
    bit neg;
    longint c;
    r = '0;
    neg = 1'b0;
    s = slot_of(ka);
    d = slot_of(kb);
    if (s < 0 || d < 0) begin
      r.status = ST_UNKNOWN;
      return r;
    end
    foreach (reached[i]) begin
      reached[i] = 1'b0;
      dist_v[i] = 0;
    end
    reached[s] = 1'b1;
    for (int rd = 0; rd < node_cnt; rd++)
      for (int i = 0; i < node_cnt; i++)
        for (int j = 0; j < node_cnt; j++) begin
          if (reached[i] && edge_ok[i*NODES+j]) begin
            c = sat40(dist_v[i] + edge_w[i*NODES+j]);
            if (!reached[j] || c < dist_v[j]) begin
              reached[j] = 1'b1;
              dist_v[j] = c;
            end
          end
        end
    for (int i = 0; i < node_cnt; i++)
      for (int j = 0; j < node_cnt; j++) begin
        if (reached[i] && edge_ok[i*NODES+j]) begin
          if (!reached[j] || dist_v[i] + edge_w[i*NODES+j] < dist_v[j]) neg = 1'b1;
        end
      end
    if (neg) r.status = ST_NEGCYC;
    else if (!reached[d]) r.status = ST_UNREACH;
    else begin
      r.status = ST_OK;
      r.distance = dist_v[d][39:0];
    end
    return r;
  endfunction

  function automatic void graph_update(in_t it);
    int s;
    int d;
    case (it.op)
      OP_CLEAR: graph_clear();
      OP_APPEND: begin
        if (node_cnt < NODES) begin
          key_tab[node_cnt] = it.key_a;
          node_cnt++;
        end
      end
      OP_EDGE: begin
        s = slot_of(it.key_a);
        d = slot_of(it.key_b);
        if (s >= 0 && d >= 0) begin
          edge_ok[s*NODES+d] = 1'b1;
          edge_w[s*NODES+d] = longint'(it.weight);
        end
      end
      default: answer_q.push_back(path_answer(it.key_a, it.key_b));
    endcase
  endfunction

  task automatic send_item(logic [1:0] op, logic [15:0] ka, logic [15:0] kb, logic [31:0] w);
    in_t it;
    it.op = op;
    it.key_a = ka;
    it.key_b = kb;
    it.weight = w;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    graph_update(it);
  endtask

  // receiver stall, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (answer_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: status %0d distance %0d",
                                       out_data.status, out_data.distance);
      end else begin
        e = answer_q.pop_front();
        if (e.status != out_data.status || e.distance != out_data.distance) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d distance %0d, got status %0d distance %0d",
                     e.status, e.distance, out_data.status, out_data.distance);
        end
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(OP_CLEAR, 16'h0, 16'h0, 32'h0);
    send_item(OP_QUERY, 16'h0001, 16'h0002, 32'h0);
    send_item(OP_APPEND, 16'h0000, 16'h0, 32'h0);
    send_item(OP_APPEND, 16'hFFFF, 16'h0, 32'h0);
    send_item(OP_APPEND, 16'h1234, 16'h0, 32'h0);
    send_item(OP_APPEND, 16'h1234, 16'h0, 32'h0);
    send_item(OP_APPEND, 16'hA5A5, 16'h0, 32'h0);
    send_item(OP_EDGE, 16'h0000, 16'hFFFF, 32'h7FFFFFFF);
    send_item(OP_EDGE, 16'hFFFF, 16'h1234, 32'h7FFFFFFF);
    send_item(OP_EDGE, 16'h1234, 16'hA5A5, 32'h80000000);
    send_item(OP_EDGE, 16'hBEEF, 16'h0000, 32'd5);
    send_item(OP_QUERY, 16'h0000, 16'hA5A5, 32'h0);
    send_item(OP_QUERY, 16'hA5A5, 16'h0000, 32'h0);
    send_item(OP_QUERY, 16'h0000, 16'h0000, 32'h0);
    send_item(OP_QUERY, 16'h0000, 16'hBEEF, 32'hFFFFFFFF);
    send_item(OP_EDGE, 16'hA5A5, 16'h1234, 32'd100);
    send_item(OP_QUERY, 16'h0000, 16'hFFFF, 32'h0);
    send_item(OP_CLEAR, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF);
    send_item(OP_QUERY, 16'h0000, 16'h0000, 32'h0);
  endtask

  task automatic test_table_full();
    send_item(OP_CLEAR, 16'h0, 16'h0, 32'h0);
    for (int i = 0; i <= NODES; i++) send_item(OP_APPEND, 16'(16'h0100 + i), 16'h0, 32'h0);
    send_item(OP_QUERY, 16'(16'h0100 + NODES), 16'h0100, 32'h0);
    send_item(OP_QUERY, 16'h0100, 16'(16'h0100 + NODES), 32'h0);
  endtask

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(9))
      7: return 32'h7FFFFFFF;
      8: return 32'h80000000;
      9: return $urandom;
      default: return 32'($signed($urandom_range(200)) - 20);
    endcase
  endfunction

  // one random graph followed by a few queries, with some noise items
  task automatic test_random_graph();
    logic [15:0] keys[8];
    int n;
    n = $urandom_range(2, 6);
    send_item(OP_CLEAR, 16'($urandom), 16'($urandom), $urandom);
    for (int i = 0; i < n; i++) begin
      keys[i] = ($urandom_range(9) == 0 && i > 0) ? keys[i-1] : 16'($urandom);
      send_item(OP_APPEND, keys[i], 16'($urandom), $urandom);
    end
    for (int i = 0; i < n + 2; i++) begin
      if ($urandom_range(7) == 0) send_item(OP_EDGE, 16'($urandom), keys[$urandom_range(n-1)],
                                            pick_weight());
      else send_item(OP_EDGE, keys[$urandom_range(n-1)], keys[$urandom_range(n-1)],
                     pick_weight());
    end
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(5) == 0) send_item(OP_QUERY, keys[$urandom_range(n-1)],
                                            16'($urandom), $urandom);
      else send_item(OP_QUERY, keys[$urandom_range(n-1)], keys[$urandom_range(n-1)], $urandom);
    end
  endtask

  task automatic test_random_phase(int idle_pct, int stall, int graphs);
    send_idle_pct = idle_pct;
    stall_pct = stall;
    for (int g = 0; g < graphs; g++) test_random_graph();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    send_item(OP_CLEAR, 16'h0, 16'h0, 32'h0);
    send_item(OP_APPEND, 16'h0011, 16'h0, 32'h0);
    send_item(OP_APPEND, 16'h0022, 16'h0, 32'h0);
    send_item(OP_EDGE, 16'h0011, 16'h0022, 32'd7);
    hold_left = 3000;
    for (int i = 0; i < 6; i++) send_item(OP_QUERY, 16'h0011, 16'h0022, 32'h0);
  endtask

  initial begin
    graph_clear();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_table_full();
    test_random_phase(0, 0, 1);
    test_random_phase(56, 0, 1);
    test_random_phase(0, 56, 1);
    test_random_phase(37, 37, 1);
    test_backpressure();
    in_valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && answer_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* bellman_ford_shortest_path_core.f */
rtl/bfsp_pkg.sv
rtl/bfsp_ram.sv
rtl/bellman_ford_shortest_path_core.sv
bench/bellman_ford_shortest_path_core_tb.sv
